@@ src/frx_pkg.sv @@
// Package: shared types, constants and functions of the framed packet receiver.
`timescale 1ns / 1ps
package frx_pkg;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  SLAVE_ID_RESET    = 8'h01;
   localparam logic [15:0] HEADER_WORD_RESET = 16'hAACC;
   localparam logic [15:0] TAIL_WORD_RESET   = 16'hAAEE;
   localparam logic [7:0]  SLAVE_ID_SEND     = 8'h01;
   localparam logic [7:0]  SLAVE_ID_RECV     = 8'h02;

   typedef enum logic [1:0] {
      CSR_SLAVE_ID    = 2'd0,
      CSR_HEADER_WORD = 2'd1,
      CSR_TAIL_WORD   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_HDR_HI  = 4'd0,
      PH_HDR_LO  = 4'd1,
      PH_ID      = 4'd2,
      PH_CMD     = 4'd3,
      PH_DATA    = 4'd4,
      PH_CRC_LO  = 4'd5,
      PH_CRC_HI  = 4'd6,
      PH_TAIL_HI = 4'd7,
      PH_TAIL_LO = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0]  slave_id;
      logic [15:0] header_word;
      logic [15:0] tail_word;
   } cfg_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] frame_command;
      logic       frame_done;
      logic       crc_error;
      logic       bad_command;
   } rsp_type;

   typedef struct packed {
      logic       found;
      logic [5:0] len_send;
      logic [5:0] len_recv;
   } frame_entry_type;

   // Frame type ROM: command byte to payload length, send and receive columns.
   function automatic frame_entry_type frame_lookup(input logic [7:0] cmd);
      frame_entry_type e;
      e = '{found: 1'b1, len_send: 6'd0, len_recv: 6'd0};
      case (cmd)
         8'h11: begin e.len_send = 6'd1;  e.len_recv = 6'd5;  end
         8'h12: begin e.len_send = 6'd5;  e.len_recv = 6'd1;  end
         8'h13: begin e.len_send = 6'd1;  e.len_recv = 6'd5;  end
         8'h2A: begin e.len_send = 6'd1;  e.len_recv = 6'd1;  end
         8'h2C: begin e.len_send = 6'd1;  e.len_recv = 6'd1;  end
         8'h2E: begin e.len_send = 6'd0;  e.len_recv = 6'd2;  end
         8'h31: begin e.len_send = 6'd0;  e.len_recv = 6'd1;  end
         8'h34: begin e.len_send = 6'd8;  e.len_recv = 6'd1;  end
         8'h35: begin e.len_send = 6'd8;  e.len_recv = 6'd1;  end
         8'h36: begin e.len_send = 6'd5;  e.len_recv = 6'd1;  end
         8'h37: begin e.len_send = 6'd5;  e.len_recv = 6'd1;  end
         8'h38: begin e.len_send = 6'd4;  e.len_recv = 6'd1;  end
         8'h39: begin e.len_send = 6'd4;  e.len_recv = 6'd1;  end
         8'h3A: begin e.len_send = 6'd4;  e.len_recv = 6'd1;  end
         8'h3D: begin e.len_send = 6'd0;  e.len_recv = 6'd0;  end
         8'h3E: begin e.len_send = 6'd0;  e.len_recv = 6'd0;  end
         8'h3F: begin e.len_send = 6'd8;  e.len_recv = 6'd0;  end
         8'h40: begin e.len_send = 6'd0;  e.len_recv = 6'd5;  end
         8'h42: begin e.len_send = 6'd0;  e.len_recv = 6'd21; end
         8'h43: begin e.len_send = 6'd0;  e.len_recv = 6'd33; end
         8'h50: begin e.len_send = 6'd4;  e.len_recv = 6'd1;  end
         8'h51: begin e.len_send = 6'd0;  e.len_recv = 6'd5;  end
         8'h53: begin e.len_send = 6'd0;  e.len_recv = 6'd5;  end
         8'h56: begin e.len_send = 6'd0;  e.len_recv = 6'd1;  end
         8'h58: begin e.len_send = 6'd1;  e.len_recv = 6'd1;  end
         8'h80: begin e.len_send = 6'd40; e.len_recv = 6'd1;  end
         8'h81: begin e.len_send = 6'd40; e.len_recv = 6'd1;  end
         8'h82: begin e.len_send = 6'd37; e.len_recv = 6'd1;  end
         default: e.found = 1'b0;
      endcase
      return e;
   endfunction

   // CRC-16/Modbus update over one byte, LSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ src/frx_if.sv @@
// Interfaces: byte input, result output and register write channels.
`timescale 1ns / 1ps
interface frx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frx_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] frame_command;
   logic       frame_done;
   logic       crc_error;
   logic       bad_command;
   modport source (output valid, output payload_valid, output payload_byte,
                   output frame_command, output frame_done, output crc_error,
                   output bad_command, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input frame_command, input frame_done, input crc_error,
                   input bad_command, output ready);
endinterface

interface frx_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/frx_csr.sv @@
// Configuration registers: slave id, header word and tail word.
`timescale 1ns / 1ps
module frx_csr (
   input  logic              clock,
   input  logic              reset,
   frx_csr_if.sink           csr_chan,
   output frx_pkg::cfg_type  cfg
);
   import frx_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SLAVE_ID:    cfg_in.slave_id    = csr_chan.data[7:0];
            CSR_HEADER_WORD: cfg_in.header_word = csr_chan.data;
            CSR_TAIL_WORD:   cfg_in.tail_word   = csr_chan.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_id    <= SLAVE_ID_RESET;
         cfg_ff.header_word <= HEADER_WORD_RESET;
         cfg_ff.tail_word   <= TAIL_WORD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/frx_parser.sv @@
// Frame parser: phase state machine, running CRC and per-byte result.
`timescale 1ns / 1ps
module frx_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   input  frx_pkg::cfg_type  cfg,
   output frx_pkg::rsp_type  result
);
   import frx_pkg::*;

   phase_type       phase_ff, phase_in;
   logic [5:0]      bytes_left_ff, bytes_left_in;
   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      crc_low_ff, crc_low_in;
   logic [7:0]      command_ff, command_in;
   logic            column_ff, column_in;
   logic [15:0]     crc_next;
   frame_entry_type entry;

   assign crc_next = crc16_byte(crc_ff, rx_byte);
   assign entry    = frame_lookup(rx_byte);

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      crc_in        = crc_ff;
      crc_low_in    = crc_low_ff;
      command_in    = command_ff;
      column_in     = column_ff;
      result        = '0;

      unique case (phase_ff)
         PH_HDR_LO: begin
            if (rx_byte == cfg.header_word[7:0]) begin
               crc_in   = CRC_INIT;
               phase_in = PH_ID;
            end
         end
         PH_ID: begin
            if (rx_byte == cfg.slave_id) begin
               crc_in   = crc_next;
               phase_in = PH_CMD;
            end
         end
         PH_CMD: begin
            command_in = rx_byte;
            if (entry.found) begin
               if (cfg.slave_id == SLAVE_ID_SEND) column_in = 1'b0;
               else if (cfg.slave_id == SLAVE_ID_RECV) column_in = 1'b1;
               bytes_left_in = column_in ? entry.len_recv : entry.len_send;
               crc_in        = crc_next;
               phase_in      = (bytes_left_in == 6'd0) ? PH_CRC_LO : PH_DATA;
            end else begin
               result.bad_command = 1'b1;
               phase_in           = PH_HDR_HI;
            end
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            crc_in               = crc_next;
            bytes_left_in        = bytes_left_ff - 6'd1;
            if (bytes_left_in == 6'd0) phase_in = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crc_low_in = rx_byte;
            phase_in   = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            if ({rx_byte, crc_low_ff} == crc_ff) begin
               phase_in = PH_TAIL_HI;
            end else begin
               result.crc_error = 1'b1;
               phase_in         = PH_HDR_HI;
            end
         end
         PH_TAIL_HI: begin
            if (rx_byte == cfg.tail_word[15:8]) phase_in = PH_TAIL_LO;
         end
         PH_TAIL_LO: begin
            if (rx_byte == cfg.tail_word[7:0]) begin
               result.frame_done = 1'b1;
               phase_in          = PH_HDR_HI;
            end
         end
         default: begin
            // header hunt
            phase_in = (rx_byte == cfg.header_word[15:8]) ? PH_HDR_LO : PH_HDR_HI;
         end
      endcase

      result.frame_command = command_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR_HI;
         bytes_left_ff <= 6'd0;
         crc_ff        <= CRC_INIT;
         crc_low_ff    <= 8'h00;
         command_ff    <= 8'h00;
         column_ff     <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
         crc_low_ff    <= crc_low_in;
         command_ff    <= command_in;
         column_ff     <= column_in;
      end
   end

endmodule

@@ src/framed_packet_receiver_crc16.sv @@
// Top level: framed packet receiver with CRC-16/Modbus check.
//
// req_chan carries one received serial byte per transfer. Every accepted
// byte yields exactly one transfer on rsp_chan: payload_valid/payload_byte
// for payload bytes, frame_command for the frame in progress, and the
// flags frame_done, crc_error and bad_command.
// csr_chan writes slave_id (index 0), header_word (1) and tail_word (2);
// it is always ready. Write it only while no byte is in flight.
// A byte accepted into the input register has its result registered once
// the result register is free, and rsp_chan.valid then rises. Throughput
// is one byte per cycle while rsp_chan does not stall; the parse step (table
// lookup plus one CRC byte update) sits between the input register and
// the result register.
// Reset (synchronous, active high) empties both registers, returns the
// parser to the header hunt with CRC 0xFFFF and restores the register
// defaults. When the rsp_chan sink stalls, the result holds and one more
// byte is taken into the input register; then req_chan.ready drops.
`timescale 1ns / 1ps
module framed_packet_receiver_crc16 (
   input  logic       clock,
   input  logic       reset,
   frx_req_if.sink    req_chan,
   frx_rsp_if.source  rsp_chan,
   frx_csr_if.sink    csr_chan
);
   import frx_pkg::*;

   cfg_type    cfg;
   rsp_type    result;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic       out_free;
   logic       advance;
   logic       req_xfer;

   frx_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   frx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_chan.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on transfer, otherwise hold
   always_ff @(posedge clock) begin
      if (req_xfer) in_byte_ff <= req_chan.rx_byte;
      if (advance) out_ff <= result;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.payload_valid = out_ff.payload_valid;
   assign rsp_chan.payload_byte  = out_ff.payload_byte;
   assign rsp_chan.frame_command = out_ff.frame_command;
   assign rsp_chan.frame_done    = out_ff.frame_done;
   assign rsp_chan.crc_error     = out_ff.crc_error;
   assign rsp_chan.bad_command   = out_ff.bad_command;

endmodule

@@ verif/tb_top.sv @@
// Testbench for the framed packet receiver: byte stimulus, per-byte predictor, result check.
`timescale 1ns / 1ps
module tb_top;
   import frx_pkg::*;

   localparam logic [15:0] CRC_SEED      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
   localparam int          FRAME_TYPES   = 28;
   localparam int          BYTES_PER_PHASE = 45;

   localparam logic [7:0] CMD_NO_PAYLOAD = 8'h3D;
   localparam logic [7:0] CMD_RESERVED   = 8'h99;
   localparam logic [7:0] CMD_SHORT      = 8'h11;

   // {command, send-column length, receive-column length}
   localparam logic [FRAME_TYPES*20-1:0] FRAME_TABLE = {
      8'h11, 6'd1,  6'd5,  8'h12, 6'd5,  6'd1,  8'h13, 6'd1,  6'd5,
      8'h2A, 6'd1,  6'd1,  8'h2C, 6'd1,  6'd1,  8'h2E, 6'd0,  6'd2,
      8'h31, 6'd0,  6'd1,  8'h34, 6'd8,  6'd1,  8'h35, 6'd8,  6'd1,
      8'h36, 6'd5,  6'd1,  8'h37, 6'd5,  6'd1,  8'h38, 6'd4,  6'd1,
      8'h39, 6'd4,  6'd1,  8'h3A, 6'd4,  6'd1,  8'h3D, 6'd0,  6'd0,
      8'h3E, 6'd0,  6'd0,  8'h3F, 6'd8,  6'd0,  8'h40, 6'd0,  6'd5,
      8'h42, 6'd0,  6'd21, 8'h43, 6'd0,  6'd33, 8'h50, 6'd4,  6'd1,
      8'h51, 6'd0,  6'd5,  8'h53, 6'd0,  6'd5,  8'h56, 6'd0,  6'd1,
      8'h58, 6'd1,  6'd1,  8'h80, 6'd40, 6'd1,  8'h81, 6'd40, 6'd1,
      8'h82, 6'd37, 6'd1
   };

   typedef enum logic [1:0] {
      FLT_NONE,
      FLT_BAD_CRC,
      FLT_STRAY
   } frame_fault_type;

   typedef struct {
      phase_type   phase;
      logic [5:0]  remaining;
      logic [15:0] crc;
      logic [7:0]  crc_lo_seen;
      logic [7:0]  command;
      logic        column;
   } parser_state_type;

   logic clock;
   logic reset;

   frx_req_if req_if ();
   frx_rsp_if rsp_if ();
   frx_csr_if csr_if ();

   framed_packet_receiver_crc16 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   cfg_type          cfg;
   parser_state_type parse_model;
   parser_state_type plan_model;
   logic [7:0]       tx_bytes[$];
   rsp_type          pending_results[$];
   int               n_queued;
   int               n_accepted = 0;
   int               fail_count = 0;
   int               in_gap;
   int               out_gap;
   logic             in_steady = 1'b0;
   logic             out_steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic parser_state_type parser_at_reset();
      parser_state_type st;
      st.phase       = PH_HDR_HI;
      st.remaining   = '0;
      st.crc         = CRC_SEED;
      st.crc_lo_seen = '0;
      st.command     = '0;
      st.column      = 1'b0;
      return st;
   endfunction

   function automatic logic [15:0] crc_modbus_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY_REFL;
         else c = c >> 1;
      end
      return c;
   endfunction

   // {known, send length, receive length}
   function automatic logic [12:0] frame_lengths(input logic [7:0] cmd);
      logic [19:0] e;
      logic [12:0] hit;
      hit = '0;
      for (int i = 0; i < FRAME_TYPES; i++) begin
         e = FRAME_TABLE[i*20 +: 20];
         if (e[19:12] == cmd) hit = {1'b1, e[11:0]};
      end
      return hit;
   endfunction

   function automatic rsp_type parse_byte(inout parser_state_type st, input cfg_type c,
                                          input logic [7:0] b);
      rsp_type     r;
      logic [12:0] row;
      r = '0;
      case (st.phase)
         PH_HDR_LO: begin
            if (b == c.header_word[7:0]) begin
               st.crc   = CRC_SEED;
               st.phase = PH_ID;
            end
         end
         PH_ID: begin
            if (b == c.slave_id) begin
               st.crc   = crc_modbus_step(st.crc, b);
               st.phase = PH_CMD;
            end
         end
         PH_CMD: begin
            st.command = b;
            row = frame_lengths(b);
            if (row[12]) begin
               // other ids keep the column chosen by the last frame
               if (c.slave_id == SLAVE_ID_SEND) st.column = 1'b0;
               else if (c.slave_id == SLAVE_ID_RECV) st.column = 1'b1;
               st.remaining = st.column ? row[5:0] : row[11:6];
               st.crc = crc_modbus_step(st.crc, b);
               if (st.remaining == 0) st.phase = PH_CRC_LO;
               else st.phase = PH_DATA;
            end else begin
               r.bad_command = 1'b1;
               st.phase = PH_HDR_HI;
            end
         end
         PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            st.crc       = crc_modbus_step(st.crc, b);
            st.remaining = st.remaining - 6'd1;
            if (st.remaining == 0) st.phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            st.crc_lo_seen = b;
            st.phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            if ({b, st.crc_lo_seen} == st.crc) begin
               st.phase = PH_TAIL_HI;
            end else begin
               r.crc_error = 1'b1;
               st.phase = PH_HDR_HI;
            end
         end
         PH_TAIL_HI: begin
            if (b == c.tail_word[15:8]) st.phase = PH_TAIL_LO;
         end
         PH_TAIL_LO: begin
            if (b == c.tail_word[7:0]) begin
               r.frame_done = 1'b1;
               st.phase = PH_HDR_HI;
            end
         end
         default: begin
            if (b == c.header_word[15:8]) st.phase = PH_HDR_LO;
            else st.phase = PH_HDR_HI;
         end
      endcase
      r.frame_command = st.command;
      return r;
   endfunction

   // Queue one byte and advance the lookahead copy of the parser with it.
   function automatic rsp_type queue_byte(input logic [7:0] b);
      tx_bytes.push_back(b);
      n_queued++;
      return parse_byte(plan_model, cfg, b);
   endfunction

   function automatic logic [7:0] unknown_command();
      logic [7:0]  cmd;
      logic [12:0] row;
      if ($urandom_range(0, 3) == 0) return CMD_RESERVED;
      do begin
         cmd = 8'($urandom_range(0, 255));
         row = frame_lengths(cmd);
      end while (row[12]);
      return cmd;
   endfunction

   // Emit the bytes that carry the parser through one frame, starting from
   // wherever it stands, until the frame closes one way or another.
   task automatic emit_frame(input logic [7:0] cmd, input frame_fault_type fault);
      rsp_type    r;
      logic [7:0] b;
      logic       closed;
      int         guard;
      closed = 1'b0;
      guard  = 0;
      while (!closed && guard < 100) begin
         case (plan_model.phase)
            PH_HDR_LO:  b = cfg.header_word[7:0];
            PH_ID:      b = cfg.slave_id;
            PH_CMD:     b = cmd;
            PH_DATA:    b = 8'($urandom_range(0, 255));
            PH_CRC_LO:  b = plan_model.crc[7:0];
            PH_CRC_HI: begin
               b = plan_model.crc[15:8];
               if (fault == FLT_BAD_CRC) b = b ^ 8'(1 << $urandom_range(0, 7));
            end
            PH_TAIL_HI: b = cfg.tail_word[15:8];
            PH_TAIL_LO: b = cfg.tail_word[7:0];
            default:    b = cfg.header_word[15:8];
         endcase
         // stray bytes land where the parser waits for one specific byte
         if (fault == FLT_STRAY && $urandom_range(0, 2) == 0 &&
             (plan_model.phase == PH_HDR_LO || plan_model.phase == PH_ID ||
              plan_model.phase == PH_TAIL_HI || plan_model.phase == PH_TAIL_LO))
            b = 8'($urandom_range(0, 255));
         r = queue_byte(b);
         closed = r.frame_done || r.crc_error || r.bad_command;
         guard++;
      end
   endtask

   task automatic emit_random_traffic(input int count);
      int         start;
      int         pick;
      logic [7:0] cmd;
      start = n_queued;
      while (n_queued - start < count) begin
         pick = $urandom_range(0, 99);
         cmd  = FRAME_TABLE[$urandom_range(0, FRAME_TYPES - 1)*20 + 12 +: 8];
         if (pick < 62) emit_frame(cmd, FLT_NONE);
         else if (pick < 72) emit_frame(unknown_command(), FLT_NONE);
         else if (pick < 82) emit_frame(cmd, FLT_BAD_CRC);
         else if (pick < 94) emit_frame(cmd, FLT_STRAY);
         else repeat ($urandom_range(1, 6)) void'(queue_byte(8'($urandom_range(0, 255))));
      end
   endtask

   task automatic wait_idle();
      while (n_accepted != n_queued || pending_results.size() != 0) @(posedge clock);
      // let the input and result registers drain
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_SLAVE_ID:    cfg.slave_id    = value[7:0];
         CSR_HEADER_WORD: cfg.header_word = value;
         CSR_TAIL_WORD:   cfg.tail_word   = value;
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Byte driver: present queued bytes, predict each one on its transfer.
   always @(posedge clock) begin : drive_bytes
      logic    took;
      logic    next_valid;
      rsp_type predicted;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.rx_byte <= 8'h00;
         in_gap = 0;
      end else begin
         took       = req_if.valid && req_if.ready;
         next_valid = req_if.valid && !took;
         if (took) begin
            predicted = parse_byte(parse_model, cfg, req_if.rx_byte);
            pending_results.push_back(predicted);
            n_accepted++;
         end
         if (!next_valid) begin
            if (in_gap > 0) begin
               in_gap--;
            end else if (tx_bytes.size() != 0) begin
               req_if.rx_byte <= tx_bytes.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 29) == 0) in_steady = !in_steady;
               in_gap = in_steady ? 0 : $urandom_range(0, 4);
            end
         end
         req_if.valid <= next_valid;
      end
   end

   // Result monitor: stall at random, compare each transfer with the oldest prediction.
   always @(posedge clock) begin : check_results
      logic    next_ready;
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         out_gap = 0;
      end else begin
         next_ready = rsp_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got.payload_valid = rsp_if.payload_valid;
            got.payload_byte  = rsp_if.payload_byte;
            got.frame_command = rsp_if.frame_command;
            got.frame_done    = rsp_if.frame_done;
            got.crc_error     = rsp_if.crc_error;
            got.bad_command   = rsp_if.bad_command;
            if (pending_results.size() == 0) begin
               log_failure($sformatf("%0t: result transfer with no byte outstanding", $time));
            end else begin
               want = pending_results.pop_front();
               if (got.payload_valid !== want.payload_valid ||
                   got.payload_byte  !== want.payload_byte  ||
                   got.frame_command !== want.frame_command ||
                   got.frame_done    !== want.frame_done    ||
                   got.crc_error     !== want.crc_error     ||
                   got.bad_command   !== want.bad_command)
                  log_failure($sformatf(
                     "%0t: mismatch want pv=%0b pb=%h cmd=%h done=%0b crc_err=%0b bad_cmd=%0b%s",
                     $time, want.payload_valid, want.payload_byte, want.frame_command,
                     want.frame_done, want.crc_error, want.bad_command,
                     $sformatf(" got pv=%0b pb=%h cmd=%h done=%0b crc_err=%0b bad_cmd=%0b",
                        got.payload_valid, got.payload_byte, got.frame_command,
                        got.frame_done, got.crc_error, got.bad_command)));
            end
            if ($urandom_range(0, 29) == 0) out_steady = !out_steady;
            out_gap = out_steady ? 0 : $urandom_range(0, 4);
            next_ready = (out_gap == 0);
         end else if (!rsp_if.ready) begin
            if (out_gap > 0) out_gap--;
            next_ready = (out_gap == 0);
         end
         rsp_if.ready <= next_ready;
      end
   end

   initial begin : stimulus
      cfg_type     next_cfg;
      logic [15:0] shared_word;
      reset = 1'b1;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= CSR_SLAVE_ID;
      csr_if.data    <= 16'h0000;
      cfg.slave_id    = SLAVE_ID_RESET;
      cfg.header_word = HEADER_WORD_RESET;
      cfg.tail_word   = TAIL_WORD_RESET;
      parse_model = parser_at_reset();
      plan_model  = parser_at_reset();
      n_queued   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // noise at both byte extremes, then a header high byte and a low byte that does not match
      void'(queue_byte(8'h00));
      void'(queue_byte(8'hFF));
      void'(queue_byte(cfg.header_word[15:8]));
      void'(queue_byte(8'h00));
      emit_frame(CMD_NO_PAYLOAD, FLT_NONE);
      emit_frame(CMD_RESERVED, FLT_NONE);
      emit_frame(CMD_SHORT, FLT_BAD_CRC);
      emit_random_traffic(BYTES_PER_PHASE);

      for (int ph = 1; ph <= 7; ph++) begin
         wait_idle();
         shared_word = 16'($urandom_range(0, 65535));
         case (ph)
            1: next_cfg = '{SLAVE_ID_RECV, HEADER_WORD_RESET, TAIL_WORD_RESET};
            2: next_cfg = '{8'h00, 16'h0000, 16'h0000};
            3: next_cfg = '{8'hFF, 16'hFFFF, 16'hFFFF};
            4: next_cfg = '{8'($urandom_range(3, 254)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535))};
            5: next_cfg = '{SLAVE_ID_SEND, shared_word, shared_word};
            6: next_cfg = '{SLAVE_ID_RECV, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535))};
            default: next_cfg = '{8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535))};
         endcase
         write_reg(CSR_SLAVE_ID, {8'h00, next_cfg.slave_id});
         write_reg(CSR_HEADER_WORD, next_cfg.header_word);
         write_reg(CSR_TAIL_WORD, next_cfg.tail_word);
         emit_random_traffic(BYTES_PER_PHASE);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
